### hdl/bvp_pkg.sv
package bvp_pkg;

    localparam int TABLE_LEN   = 19;
    localparam int SEG_W       = 5;
    localparam int BRK_W       = 12;
    localparam int CMP_W       = 16;
    localparam int DIFF_W      = 6;
    localparam int MUL_W       = 9;
    localparam int NUM_W       = 17;
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP_W     = 20;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int DROP_W      = 12;
    localparam int OUT_W       = 15;

    localparam int RECIP_ONE = 2 ** RECIP_SHIFT;

    localparam logic [OUT_W-1:0] FULL_Q8  = 15'd25600;
    localparam logic [OUT_W-1:0] FLOOR_Q8 = 15'd1280;

    // Descending breakpoints in millivolts
    localparam logic [BRK_W-1:0] BRK_MV [TABLE_LEN] = '{
        12'd4033, 12'd4002, 12'd3952, 12'd3913, 12'd3890, 12'd3863, 12'd3838,
        12'd3815, 12'd3795, 12'd3778, 12'd3757, 12'd3742, 12'd3724, 12'd3706,
        12'd3684, 12'd3663, 12'd3644, 12'd3627, 12'd3594
    };

    // ceil(2^RECIP_SHIFT / span) for the segment ending at each breakpoint
    localparam logic [RECIP_W-1:0] SEG_RECIP [TABLE_LEN] = '{
        20'd0,
        RECIP_W'((RECIP_ONE + (4033 - 4002) - 1) / (4033 - 4002)),
        RECIP_W'((RECIP_ONE + (4002 - 3952) - 1) / (4002 - 3952)),
        RECIP_W'((RECIP_ONE + (3952 - 3913) - 1) / (3952 - 3913)),
        RECIP_W'((RECIP_ONE + (3913 - 3890) - 1) / (3913 - 3890)),
        RECIP_W'((RECIP_ONE + (3890 - 3863) - 1) / (3890 - 3863)),
        RECIP_W'((RECIP_ONE + (3863 - 3838) - 1) / (3863 - 3838)),
        RECIP_W'((RECIP_ONE + (3838 - 3815) - 1) / (3838 - 3815)),
        RECIP_W'((RECIP_ONE + (3815 - 3795) - 1) / (3815 - 3795)),
        RECIP_W'((RECIP_ONE + (3795 - 3778) - 1) / (3795 - 3778)),
        RECIP_W'((RECIP_ONE + (3778 - 3757) - 1) / (3778 - 3757)),
        RECIP_W'((RECIP_ONE + (3757 - 3742) - 1) / (3757 - 3742)),
        RECIP_W'((RECIP_ONE + (3742 - 3724) - 1) / (3742 - 3724)),
        RECIP_W'((RECIP_ONE + (3724 - 3706) - 1) / (3724 - 3706)),
        RECIP_W'((RECIP_ONE + (3706 - 3684) - 1) / (3706 - 3684)),
        RECIP_W'((RECIP_ONE + (3684 - 3663) - 1) / (3684 - 3663)),
        RECIP_W'((RECIP_ONE + (3663 - 3644) - 1) / (3663 - 3644)),
        RECIP_W'((RECIP_ONE + (3644 - 3627) - 1) / (3644 - 3627)),
        RECIP_W'((RECIP_ONE + (3627 - 3594) - 1) / (3627 - 3594))
    };

    typedef struct packed {
        logic [OUT_W-1:0] base_q8;
        logic [SEG_W-1:0] seg;
        logic             flat;
    } seg_sel_t;

    typedef struct packed {
        logic [OUT_W-1:0]  base_q8;
        logic [DROP_W-1:0] drop_q8;
    } drop_res_t;

    // Segment base in Q.8: 100 percent less 5 percent per segment
    function automatic logic [OUT_W-1:0] seg_base_q8(input logic [SEG_W-1:0] seg);
        logic [OUT_W-1:0] steps;
        steps = OUT_W'(seg) - OUT_W'(1);
        return FULL_Q8 - ((steps << 10) + (steps << 8));
    endfunction

endpackage

### hdl/battery_voltage_to_percent.sv
// Channel   Ports                               Direction  Content
// input     s_valid, s_ready, s_voltage_mv      in         voltage sample, mV
// result    m_valid, m_ready, m_percent_q8      out        charge, percent x 256
//
// Four register stages: segment search, numerator, reciprocal multiply,
// output subtract. One transfer can enter every cycle while m_ready does not stall the output.
// The rate is set by the single 17 x 20 reciprocal multiplier, one per cycle.
// aresetn is synchronous, active low, and clears the valid bits only.
// A stall on m_ready holds every full stage in place; empty stages still fill.
module battery_voltage_to_percent
    import bvp_pkg::*;
#(
    parameter int NUM_POINTS = 19,
    parameter int VOLT_BITS  = 13
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [VOLT_BITS-1:0] s_voltage_mv,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_W-1:0]     m_percent_q8
);

    logic                 sf_valid;
    logic                 sf_ready;
    logic [VOLT_BITS-1:0] sf_volt;
    seg_sel_t             sf_sel;

    logic                 dr_valid;
    logic                 dr_ready;
    drop_res_t            dr_res;

    logic                 out_vld_reg;
    logic [OUT_W-1:0]     out_pct_reg;
    logic [OUT_W-1:0]     out_pct_next;
    logic                 out_adv;

    // Stage A: find the segment the sample falls in
    bvp_seg_find #(
        .NUM_POINTS (NUM_POINTS),
        .VOLT_BITS  (VOLT_BITS)
    ) u_seg_find (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_volt   (s_voltage_mv),
        .out_valid (sf_valid),
        .out_ready (sf_ready),
        .out_volt  (sf_volt),
        .out_sel   (sf_sel)
    );

    // Stages B and C: interpolated drop via reciprocal of the segment span
    bvp_drop #(
        .NUM_POINTS (NUM_POINTS),
        .VOLT_BITS  (VOLT_BITS)
    ) u_drop (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sf_valid),
        .in_ready  (sf_ready),
        .in_volt   (sf_volt),
        .in_sel    (sf_sel),
        .out_valid (dr_valid),
        .out_ready (dr_ready),
        .out_res   (dr_res)
    );

    // Stage D: subtract the drop from the segment base; hold until taken
    assign out_adv      = !out_vld_reg || m_ready;
    assign dr_ready     = out_adv;
    assign out_pct_next = dr_res.base_q8 - OUT_W'(dr_res.drop_q8);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_adv) begin
            out_vld_reg <= dr_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && dr_valid) begin
            out_pct_reg <= out_pct_next;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_percent_q8 = out_pct_reg;

endmodule

### hdl/bvp_seg_find.sv
module bvp_seg_find
    import bvp_pkg::*;
#(
    parameter int NUM_POINTS = 19,
    parameter int VOLT_BITS  = 13
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [VOLT_BITS-1:0] in_volt,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [VOLT_BITS-1:0] out_volt,
    output seg_sel_t             out_sel
);

    localparam int NPTS = (NUM_POINTS > TABLE_LEN) ? TABLE_LEN :
                          (NUM_POINTS < 2) ? 2 : NUM_POINTS;

    logic                 vld_reg;
    logic [VOLT_BITS-1:0] volt_reg;
    seg_sel_t             sel_reg;
    seg_sel_t             sel_next;
    logic                 adv;

    assign adv      = !vld_reg || out_ready;
    assign in_ready = adv;

    // Compare against every breakpoint at once; the lowest index hit wins
    always_comb begin
        logic [CMP_W-1:0] vx;
        logic             hit;
        logic             full;
        logic [SEG_W-1:0] seg;
        vx   = CMP_W'(in_volt);
        hit  = 1'b0;
        seg  = SEG_W'(1);
        full = vx > CMP_W'(BRK_MV[0]);
        for (int k = TABLE_LEN - 1; k >= 1; k--) begin
            if (k < NPTS && vx > CMP_W'(BRK_MV[k])) begin
                hit = 1'b1;
                seg = SEG_W'(k);
            end
        end
        sel_next.seg  = seg;
        sel_next.flat = full || !hit;
        if (full) begin
            sel_next.base_q8 = FULL_Q8;
        end else if (!hit) begin
            sel_next.base_q8 = FLOOR_Q8;
        end else begin
            sel_next.base_q8 = seg_base_q8(seg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_valid) begin
            volt_reg <= in_volt;
            sel_reg  <= sel_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_volt  = volt_reg;
    assign out_sel   = sel_reg;

endmodule

### hdl/bvp_drop.sv
module bvp_drop
    import bvp_pkg::*;
#(
    parameter int NUM_POINTS = 19,
    parameter int VOLT_BITS  = 13
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [VOLT_BITS-1:0] in_volt,
    input  seg_sel_t             in_sel,
    output logic                 out_valid,
    input  logic                 out_ready,
    output drop_res_t            out_res
);

    localparam int NPTS = (NUM_POINTS > TABLE_LEN) ? TABLE_LEN :
                          (NUM_POINTS < 2) ? 2 : NUM_POINTS;
    localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(NPTS - 1);

    // Stage B: scaled numerator
    logic              b_vld_reg;
    logic              b_adv;
    logic [NUM_W-1:0]  b_num_reg;
    logic [NUM_W-1:0]  b_num_next;
    logic [SEG_W-1:0]  b_seg_reg;
    logic [OUT_W-1:0]  b_base_reg;

    // Stage C: reciprocal product
    logic              c_vld_reg;
    logic              c_adv;
    drop_res_t         c_res_reg;
    drop_res_t         c_res_next;

    assign c_adv    = !c_vld_reg || out_ready;
    assign b_adv    = !b_vld_reg || c_adv;
    assign in_ready = b_adv;

    always_comb begin
        logic [CMP_W-1:0]  diff;
        logic [DIFF_W-1:0] d;
        logic [MUL_W-1:0]  m;
        diff = CMP_W'(BRK_MV[in_sel.seg - SEG_W'(1)]) - CMP_W'(in_volt);
        d    = in_sel.flat ? '0 : diff[DIFF_W-1:0];
        if (in_sel.seg == LAST_SEG) begin
            m = (MUL_W'(d) << 3) + (MUL_W'(d) << 1);
        end else begin
            m = (MUL_W'(d) << 2) + MUL_W'(d);
        end
        b_num_next = {m, 8'b0};
    end

    always_comb begin
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(b_num_reg) * PROD_W'(SEG_RECIP[b_seg_reg]);
        c_res_next.base_q8 = b_base_reg;
        c_res_next.drop_q8 = prod[RECIP_SHIFT +: DROP_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else begin
            if (b_adv) begin
                b_vld_reg <= in_valid;
            end
            if (c_adv) begin
                c_vld_reg <= b_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv && in_valid) begin
            b_num_reg  <= b_num_next;
            b_seg_reg  <= in_sel.seg;
            b_base_reg <= in_sel.base_q8;
        end
        if (c_adv && b_vld_reg) begin
            c_res_reg <= c_res_next;
        end
    end

    assign out_valid = c_vld_reg;
    assign out_res   = c_res_reg;

endmodule

### test/battery_voltage_to_percent_test.sv
module battery_voltage_to_percent_test
    import bvp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_POINTS = 19;
    localparam int VOLT_BITS  = 13;
    localparam int STALL_LIMIT = 4000;    // cycles without a transfer before giving up
    localparam int RANDOM_SAMPLES = 900;

    // Expected-result store and predictor for the voltage-to-charge map.
    class charge_scoreboard;
        typedef struct {
            logic [VOLT_BITS-1:0] voltage;
            logic [OUT_W-1:0]     charge;
        } charge_entry_t;

        charge_entry_t expected_q[$];
        int            errors;

        static const int KNEE_MV [19] = '{
            4033, 4002, 3952, 3913, 3890, 3863, 3838, 3815, 3795, 3778,
            3757, 3742, 3724, 3706, 3684, 3663, 3644, 3627, 3594
        };

        function new();
            errors = 0;
        endfunction

        static function logic [OUT_W-1:0] charge_of(logic [VOLT_BITS-1:0] voltage);
            int unsigned n_knees;
            int unsigned v;
            int unsigned upper;
            int unsigned span;
            int unsigned slope;
            int unsigned base;
            n_knees = (NUM_POINTS > 19) ? 19 : ((NUM_POINTS < 2) ? 2 : NUM_POINTS);
            v = 32'(voltage);
            if (v > KNEE_MV[0])
                return OUT_W'(100 * 256);
            for (int unsigned k = 1; k < n_knees; k++) begin
                if (v > KNEE_MV[k]) begin
                    upper = KNEE_MV[k-1];
                    span  = upper - KNEE_MV[k];
                    slope = (k == n_knees - 1) ? 10 : 5;
                    base  = 100 - 5 * (k - 1);
                    if (span == 0)
                        return OUT_W'(base * 256);
                    return OUT_W'(base * 256 - ((upper - v) * slope * 256) / span);
                end
            end
            return OUT_W'(5 * 256);
        endfunction

        function void note_sample(logic [VOLT_BITS-1:0] voltage);
            charge_entry_t e;
            e.voltage = voltage;
            e.charge  = charge_of(voltage);
            expected_q.push_back(e);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_charge(logic [OUT_W-1:0] charge);
            charge_entry_t e;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result percent_q8=%0d", charge));
                return;
            end
            e = expected_q.pop_front();
            if (charge !== e.charge)
                report_mismatch($sformatf("voltage %0d mV: percent_q8 %0d, expected %0d",
                                          e.voltage, charge, e.charge));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [VOLT_BITS-1:0] s_voltage_mv;
    logic                 m_valid;
    logic                 m_ready;
    logic [OUT_W-1:0]     m_percent_q8;

    charge_scoreboard sb;

    // Burst/gap state of the sender: the number of transfers left in this burst.
    int burst_left;
    int idle_cycles;
    int stall_mode;
    int stall_count;

    battery_voltage_to_percent #(
        .NUM_POINTS (NUM_POINTS),
        .VOLT_BITS  (VOLT_BITS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_voltage_mv (s_voltage_mv),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_percent_q8 (m_percent_q8)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Present one sample and hold it until the block takes it. Between bursts,
    // drop valid for a random gap so idle cycles land on every pipeline phase.
    task send_sample(input logic [VOLT_BITS-1:0] voltage);
        int gap;
        s_valid      <= 1'b1;
        s_voltage_mv <= voltage;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(voltage);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // Start a fresh burst; sometimes with no gap at all
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
            if (gap > 0) begin
                s_valid      <= 1'b0;
                s_voltage_mv <= VOLT_BITS'($urandom);
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Pick a voltage that mostly lands inside the table, often on or near a knee.
    function automatic logic [VOLT_BITS-1:0] pick_voltage();
        int unsigned roll;
        int          knee;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return VOLT_BITS'($urandom_range(3580, 4050));
        if (roll < 80) begin
            knee = charge_scoreboard::KNEE_MV[$urandom_range(0, 18)];
            return VOLT_BITS'(knee + $urandom_range(0, 4) - 2);
        end
        return VOLT_BITS'($urandom);
    endfunction

    // Result side: check every transfer, then choose m_ready from a stall pattern that
    // switches between free-running, random, heavy and periodic back-pressure.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_charge(m_percent_q8);
        if (stall_count == 0) begin
            stall_mode  <= $urandom_range(0, 3);
            stall_count <= $urandom_range(10, 80);
        end else begin
            stall_count <= stall_count - 1;
        end
        case (stall_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_ready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
                m_ready <= (stall_count[2:0] != 3'd0);
            end
        endcase
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("battery_voltage_to_percent_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        sb           = new();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_voltage_mv = '0;
        m_ready      = 1'b0;
        burst_left   = 0;
        idle_cycles  = 0;
        stall_mode   = 0;
        stall_count  = 0;

        // Hold reset, then release it on an edge
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: both ends of the input range, just above the full knee,
        // exactly on every knee (base of the next segment), and either side of
        // the floor knee, where the last segment's double step applies
        send_sample('0);
        send_sample('1);
        send_sample(VOLT_BITS'(4034));
        foreach (charge_scoreboard::KNEE_MV[k])
            send_sample(VOLT_BITS'(charge_scoreboard::KNEE_MV[k]));
        send_sample(VOLT_BITS'(3595));
        send_sample(VOLT_BITS'(3593));
        send_sample(VOLT_BITS'(3626));

        // Random part
        repeat (RANDOM_SAMPLES)
            send_sample(pick_voltage());
        s_valid <= 1'b0;

        // Drain, then keep watching for any stray result
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("battery_voltage_to_percent_test passed");
        end else begin
            $display("battery_voltage_to_percent_test failed");
        end
        $finish;
    end

endmodule
